[rtl/bga_pkg.sv]
// Package for the bar graph autoscale block: widths, constants, codes and types.
// Shared by the interfaces, the divider and the top level; depends on nothing.
`default_nettype none

package bga_pkg;

  localparam int unsigned DOSE_W     = 32;
  localparam int unsigned FS_W       = 33;
  localparam int unsigned PIDX_W     = 5;
  localparam int unsigned BAR_W      = 6;
  localparam int unsigned COLOR_W    = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned POINTS_DEF     = 32;
  localparam int unsigned BAR_HEIGHT_DEF = 63;

  localparam int unsigned NUM_W     = DOSE_W + BAR_W;
  localparam int unsigned DEN_W     = FS_W;
  localparam int unsigned DIV_CNT_W = $clog2(NUM_W);

  localparam int unsigned RND_C_W = 17;

  localparam logic [DOSE_W-1:0] FS_FLOOR = DOSE_W'(50);
  localparam logic [DOSE_W-1:0] RND_T1   = DOSE_W'(1000);
  localparam logic [DOSE_W-1:0] RND_T2   = DOSE_W'(10000);
  localparam logic [DOSE_W-1:0] RND_T3   = DOSE_W'(100000);
  localparam logic [DOSE_W-1:0] RND_T4   = DOSE_W'(1000000);

  localparam logic [RND_C_W-1:0] RND_C1 = RND_C_W'(100);
  localparam logic [RND_C_W-1:0] RND_C2 = RND_C_W'(1000);
  localparam logic [RND_C_W-1:0] RND_C3 = RND_C_W'(10000);
  localparam logic [RND_C_W-1:0] RND_C4 = RND_C_W'(100000);

  localparam logic [COLOR_W-1:0] COLOR_NONE = 2'd0;
  localparam logic [COLOR_W-1:0] COLOR_L1   = 2'd1;
  localparam logic [COLOR_W-1:0] COLOR_L2   = 2'd2;
  localparam logic [COLOR_W-1:0] COLOR_L3   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL1 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL3 = 2'd2;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CHECK,
    ST_NOUPD,
    ST_ROUND,
    ST_SCALE,
    ST_SCALE_W,
    ST_READ,
    ST_PT,
    ST_PT_W,
    ST_EMIT
  } bga_state_e;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } bga_div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quot;
    logic [DEN_W-1:0] rem;
  } bga_div_rsp_t;

endpackage

`default_nettype wire

[rtl/bga_if.sv]
// Valid/ready channel interfaces for dose input and bar result output.
// Depends on bga_pkg for the field widths.
`default_nettype none

interface bga_in_if;
  import bga_pkg::*;

  logic              valid;
  logic              ready;
  logic [DOSE_W-1:0] dose;
  logic              last_point;

  modport source (output valid, output dose, output last_point, input ready);
  modport sink (input valid, input dose, input last_point, output ready);
endinterface

interface bga_out_if;
  import bga_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIDX_W-1:0]  point_index;
  logic [BAR_W-1:0]   bar_height;
  logic [COLOR_W-1:0] color_code;
  logic [BAR_W-1:0]   prev_bar_height;
  logic [COLOR_W-1:0] prev_color_code;
  logic [FS_W-1:0]    full_scale;
  logic               no_update;
  logic               last_result;

  modport source (
    output valid, output point_index, output bar_height, output color_code,
    output prev_bar_height, output prev_color_code, output full_scale,
    output no_update, output last_result, input ready
  );
  modport sink (
    input valid, input point_index, input bar_height, input color_code,
    input prev_bar_height, input prev_color_code, input full_scale,
    input no_update, input last_result, output ready
  );
endinterface

`default_nettype wire

[rtl/bga_div.sv]
// Shared restoring divider, one quotient bit per cycle, used for scale rounding,
// the scale divisor and every bar height. Depends on bga_pkg.
`default_nettype none

module bga_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bga_pkg::bga_div_req_t req_i,
  output bga_pkg::bga_div_rsp_t rsp_o
);
  import bga_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0]     quot_q;
  logic [DEN_W-1:0]     rem_q;
  logic [DEN_W-1:0]     den_q;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] rem_d;
  logic [NUM_W-1:0] quot_d;

  always_comb begin
    trial  = {rem_q, quot_q[NUM_W-1]};
    diff   = trial - {1'b0, den_q};
    ge     = (trial >= {1'b0, den_q});
    rem_d  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    quot_d = {quot_q[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(NUM_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quot_q <= req_i.num;
      rem_q  <= '0;
      den_q  <= req_i.den;
    end else if (busy_q) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

[rtl/bar_graph_autoscale_core.sv]
// Bar graph autoscale core: loads a frame of doses, rounds the maximum to a full
// scale and emits one scaled, colored bar per point. Depends on bga_pkg, bga_if, bga_div.
// Doses are accepted while a frame loads. Then the shared divider rounds the maximum when
// above RND_T1 (else it is floored at FS_FLOOR), gives the scale divisor and then each
// point's bar height; an all-zero frame gives a single no-update result instead.
// Reset clears thresholds to all ones, the previous bars to zero and the sequencer.
`default_nettype none

module bar_graph_autoscale_core #(
  parameter int unsigned POINTS     = bga_pkg::POINTS_DEF,
  parameter int unsigned BAR_HEIGHT = bga_pkg::BAR_HEIGHT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bga_in_if.sink                         in_i,
  bga_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [bga_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bga_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bga_pkg::*;

  localparam int unsigned IW = (POINTS > 1) ? $clog2(POINTS) : 1;
  localparam int unsigned CW = $clog2(POINTS + 1);

  bga_state_e state_q, state_d;

  logic [DOSE_W-1:0] lvl1_q, lvl2_q, lvl3_q;

  logic [DOSE_W-1:0]  max_q;
  logic [CW-1:0]      load_cnt_q;
  logic [IW-1:0]      idx_q;
  logic [FS_W-1:0]    fs_q;
  logic [FS_W-1:0]    fs_cur_q;
  logic [RND_C_W-1:0] rnd_c_q;
  logic [RND_C_W-1:0] rnd_c_d;
  logic               small_q;
  logic [DEN_W-1:0]   sdiv_q;
  logic [DOSE_W-1:0]  dv_q;
  logic [DOSE_W-1:0]  dv_d;
  logic [COLOR_W-1:0] color_q;
  logic [COLOR_W-1:0] color_d;
  logic [BAR_W-1:0]   h_q;
  logic [BAR_W-1:0]   h_d;

  logic [DOSE_W-1:0]          dose_mem [POINTS];
  logic [COLOR_W+BAR_W-1:0]   bar_mem [POINTS];
  logic [POINTS-1:0]          bar_vld_q;
  logic [DOSE_W-1:0]          dose_rd_q;
  logic [COLOR_W+BAR_W-1:0]   bar_rd_q;
  logic                       bar_rd_vld_q;
  logic [COLOR_W+BAR_W-1:0]   prev;

  logic               out_vld_q;
  logic [PIDX_W-1:0]  op_idx_q;
  logic [BAR_W-1:0]   op_h_q;
  logic [COLOR_W-1:0] op_c_q;
  logic [BAR_W-1:0]   op_ph_q;
  logic [COLOR_W-1:0] op_pc_q;
  logic [FS_W-1:0]    op_fs_q;
  logic               op_noupd_q;
  logic               op_last_q;

  bga_div_req_t div_req;
  bga_div_rsp_t div_rsp;

  logic in_rdy, acc, store, out_free, last_pt;
  logic fs_direct, fs_round, scale_done, rd_en, pt_start, h_ld, emit, noupd, frame_end;

  bga_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign acc      = in_i.valid & in_rdy;
  assign store    = acc && (load_cnt_q < CW'(POINTS));
  assign out_free = !out_vld_q || out_o.ready;
  assign last_pt  = (idx_q == IW'(POINTS - 1));
  assign prev     = bar_rd_vld_q ? bar_rd_q : '0;

  always_comb begin
    if (max_q > RND_T4) begin
      rnd_c_d = RND_C4;
    end else if (max_q > RND_T3) begin
      rnd_c_d = RND_C3;
    end else if (max_q > RND_T2) begin
      rnd_c_d = RND_C2;
    end else begin
      rnd_c_d = RND_C1;
    end
  end

  always_comb begin
    dv_d = (CW'(idx_q) < load_cnt_q) ? dose_rd_q : '0;
    if (dv_d >= lvl3_q) begin
      color_d = COLOR_NONE;
    end else if (dv_d >= lvl2_q) begin
      color_d = COLOR_L3;
    end else if (dv_d >= lvl1_q) begin
      color_d = COLOR_L2;
    end else begin
      color_d = COLOR_L1;
    end
  end

  always_comb begin
    if (div_rsp.quot > NUM_W'(BAR_HEIGHT)) begin
      h_d = BAR_W'(BAR_HEIGHT);
    end else if (div_rsp.quot == '0 && dv_q != '0) begin
      h_d = BAR_W'(1);
    end else begin
      h_d = div_rsp.quot[BAR_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (acc && in_i.last_point) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (max_q == '0) begin
          state_d = ST_NOUPD;
        end else if (max_q > RND_T1) begin
          state_d = ST_ROUND;
        end else begin
          state_d = ST_SCALE;
        end
      end
      ST_NOUPD: begin
        if (out_free) begin
          state_d = ST_LOAD;
        end
      end
      ST_ROUND: begin
        if (div_rsp.done) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE:   state_d = ST_SCALE_W;
      ST_SCALE_W: begin
        if (div_rsp.done) begin
          state_d = ST_READ;
        end
      end
      ST_READ:    state_d = ST_PT;
      ST_PT:      state_d = ST_PT_W;
      ST_PT_W: begin
        if (div_rsp.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = last_pt ? ST_LOAD : ST_READ;
        end
      end
      default:    state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    in_rdy     = 1'b0;
    fs_direct  = 1'b0;
    fs_round   = 1'b0;
    scale_done = 1'b0;
    rd_en      = 1'b0;
    pt_start   = 1'b0;
    h_ld       = 1'b0;
    emit       = 1'b0;
    noupd      = 1'b0;
    frame_end  = 1'b0;
    div_req    = '0;
    unique case (state_q)
      ST_LOAD: in_rdy = 1'b1;
      ST_CHECK: begin
        if (max_q > RND_T1) begin
          div_req.start = 1'b1;
          div_req.num   = NUM_W'(max_q);
          div_req.den   = DEN_W'(rnd_c_d);
        end else if (max_q != '0) begin
          fs_direct = 1'b1;
        end
      end
      ST_NOUPD: begin
        if (out_free) begin
          noupd     = 1'b1;
          frame_end = 1'b1;
        end
      end
      ST_ROUND: fs_round = div_rsp.done;
      ST_SCALE: begin
        div_req.start = 1'b1;
        div_req.num   = NUM_W'(fs_q);
        div_req.den   = DEN_W'(BAR_HEIGHT);
      end
      ST_SCALE_W: scale_done = div_rsp.done;
      ST_READ: rd_en = 1'b1;
      ST_PT: begin
        pt_start      = 1'b1;
        div_req.start = 1'b1;
        div_req.num   = small_q ? NUM_W'(dv_d) * NUM_W'(BAR_HEIGHT) : NUM_W'(dv_d);
        div_req.den   = small_q ? fs_q : sdiv_q;
      end
      ST_PT_W: h_ld = div_rsp.done;
      ST_EMIT: begin
        if (out_free) begin
          emit      = 1'b1;
          frame_end = last_pt;
        end
      end
      default: ;
    endcase
  end

  assign in_i.ready = in_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl1_q <= '1;
      lvl2_q <= '1;
      lvl3_q <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LEVEL1: lvl1_q <= cfg_data_i[DOSE_W-1:0];
        CFG_LEVEL2: lvl2_q <= cfg_data_i[DOSE_W-1:0];
        CFG_LEVEL3: lvl3_q <= cfg_data_i[DOSE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      max_q      <= '0;
      load_cnt_q <= '0;
      fs_cur_q   <= '0;
      bar_vld_q  <= '0;
      out_vld_q  <= 1'b0;
      idx_q      <= '0;
    end else begin
      state_q <= state_d;
      if (frame_end) begin
        max_q      <= '0;
        load_cnt_q <= '0;
      end else if (store) begin
        load_cnt_q <= load_cnt_q + CW'(1);
        if (in_i.dose > max_q) begin
          max_q <= in_i.dose;
        end
      end
      if (scale_done) begin
        idx_q <= '0;
      end else if (emit && !last_pt) begin
        idx_q <= idx_q + IW'(1);
      end
      if (emit) begin
        bar_vld_q[idx_q] <= 1'b1;
        if (last_pt) begin
          fs_cur_q <= fs_q;
        end
      end
      if (noupd || emit) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_req.start && state_q == ST_CHECK) begin
      rnd_c_q <= rnd_c_d;
    end
    if (fs_direct) begin
      fs_q <= (max_q < FS_FLOOR) ? FS_W'(FS_FLOOR) : FS_W'(max_q);
    end else if (fs_round) begin
      fs_q <= FS_W'(max_q) - div_rsp.rem + FS_W'(rnd_c_q);
    end
    if (scale_done) begin
      small_q <= (div_rsp.quot <= NUM_W'(1));
      sdiv_q  <= div_rsp.quot[DEN_W-1:0];
    end
    if (pt_start) begin
      dv_q    <= dv_d;
      color_q <= color_d;
    end
    if (h_ld) begin
      h_q <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      dose_mem[load_cnt_q[IW-1:0]] <= in_i.dose;
    end
    if (rd_en) begin
      dose_rd_q <= dose_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      bar_mem[idx_q] <= {color_q, h_q};
    end
    if (rd_en) begin
      bar_rd_q     <= bar_mem[idx_q];
      bar_rd_vld_q <= bar_vld_q[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (noupd) begin
      op_idx_q   <= '0;
      op_h_q     <= '0;
      op_c_q     <= COLOR_NONE;
      op_ph_q    <= '0;
      op_pc_q    <= COLOR_NONE;
      op_fs_q    <= fs_cur_q;
      op_noupd_q <= 1'b1;
      op_last_q  <= 1'b1;
    end else if (emit) begin
      op_idx_q   <= PIDX_W'(idx_q);
      op_h_q     <= h_q;
      op_c_q     <= color_q;
      op_ph_q    <= prev[BAR_W-1:0];
      op_pc_q    <= prev[COLOR_W+BAR_W-1:BAR_W];
      op_fs_q    <= fs_q;
      op_noupd_q <= 1'b0;
      op_last_q  <= last_pt;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.point_index     = op_idx_q;
  assign out_o.bar_height      = op_h_q;
  assign out_o.color_code      = op_c_q;
  assign out_o.prev_bar_height = op_ph_q;
  assign out_o.prev_color_code = op_pc_q;
  assign out_o.full_scale      = op_fs_q;
  assign out_o.no_update       = op_noupd_q;
  assign out_o.last_result     = op_last_q;

  a_div_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_load_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_cnt_q <= CW'(POINTS))
    else $error("load count beyond frame size");

  a_frame_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last_pt) |=> (state_q == ST_LOAD && max_q == '0 && load_cnt_q == '0))
    else $error("frame state not cleared after last result");

endmodule

`default_nettype wire
